// ===== rtl/page_frame_allocator_core_defines.svh =====
// Assertion macros used by the page frame allocator top level.
`ifndef PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PFA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("page frame allocator: same-cycle check failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("page frame allocator: next-cycle check failed");

`endif

// ===== rtl/pfa_pkg.sv =====
// Shared constants, types and helper functions of the page frame allocator.
`default_nettype none

package pfa_pkg;

    // Sizes of the managed memory.
    localparam int FRAMES          = 16;
    localparam int PAGES_PER_PROC  = 16;
    localparam int PROCS           = 4;
    localparam int LINES_PER_FRAME = 4;

    // Field widths of the transaction payloads.
    localparam int PROC_W      = 2;
    localparam int PAGE_W      = 4;
    localparam int START_W     = 4;
    localparam int STATUS_W    = 3;
    localparam int FRAME_W     = 4;
    localparam int LINE_ADDR_W = 6;
    localparam int FREED_W     = 5;

    // Derived internal widths.
    localparam int FIDX_W      = $clog2(FRAMES);
    localparam int COUNT_W     = $clog2(FRAMES + 1);
    localparam int MAP_ENTRIES = PROCS * PAGES_PER_PROC;
    localparam int MAP_IDX_W   = $clog2(MAP_ENTRIES);
    localparam int LINE_OFS_W  = $clog2(LINES_PER_FRAME);

    // Request function codes.
    localparam logic FUNC_MAP     = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT      = 3'd0,
        STAT_FREE     = 3'd1,
        STAT_EVICT    = 3'd2,
        STAT_NOFRAME  = 3'd3,
        STAT_RELEASED = 3'd4
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_REL_RD,
        S_REL_WR,
        S_REL_END,
        S_DONE
    } t_state;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_HIT,
        OP_ALLOC,
        OP_EVICT,
        OP_NOFRAME,
        OP_SCAN_NEXT,
        OP_REL_NEXT,
        OP_REL_FREE,
        OP_RELEASED
    } t_dp_op;

    // Command from controller to datapath.
    typedef struct packed {
        t_dp_op op;
        logic   out_load;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic func;
        logic proc_bad;
        logic page_bad;
        logic hit;
        logic free_avail;
        logic victim_ok;
        logic scan_last;
        logic rel_valid;
        logic rel_last;
        logic out_free;
    } t_stat;

    // Flat page table index of a process and page.
    function automatic logic [MAP_IDX_W-1:0] map_index(input logic [PROC_W-1:0] p,
                                                       input logic [PAGE_W-1:0] g);
        return MAP_IDX_W'(MAP_IDX_W'(p) * MAP_IDX_W'(PAGES_PER_PROC) + MAP_IDX_W'(g));
    endfunction

    // Circular increment of a frame index or queue pointer.
    function automatic logic [FIDX_W-1:0] frame_inc(input logic [FIDX_W-1:0] f);
        return (f == FIDX_W'(FRAMES - 1)) ? '0 : f + FIDX_W'(1);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pfa_ctrl.sv =====
// Controller state machine of the page frame allocator.
`default_nettype none

module pfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pfa_pkg::t_stat i_stat,
    output pfa_pkg::t_cmd  o_cmd,
    output logic           o_ready
);
    import pfa_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state        = r_state;
        o_cmd.op       = OP_NONE;
        o_cmd.out_load = 1'b0;
        o_ready        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = (i_stat.func == FUNC_RELEASE) ? S_REL_RD : S_LOOK;
                end
            end
            S_LOOK: begin
                // The page table read issued at acceptance is available now.
                if (i_stat.proc_bad || i_stat.page_bad) begin
                    o_cmd.op = OP_NOFRAME;
                    n_state  = S_DONE;
                end else if (i_stat.hit) begin
                    o_cmd.op = OP_HIT;
                    n_state  = S_DONE;
                end else if (i_stat.free_avail) begin
                    o_cmd.op = OP_ALLOC;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One candidate victim frame per cycle.
                if (i_stat.victim_ok) begin
                    o_cmd.op = OP_EVICT;
                    n_state  = S_DONE;
                end else if (i_stat.scan_last) begin
                    o_cmd.op = OP_NOFRAME;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                end
            end
            S_REL_RD: begin
                if (i_stat.proc_bad) begin
                    o_cmd.op = OP_RELEASED;
                    n_state  = S_DONE;
                end else if (i_stat.rel_valid) begin
                    n_state = S_REL_WR;
                end else if (i_stat.rel_last) begin
                    o_cmd.op = OP_RELEASED;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_REL_NEXT;
                end
            end
            S_REL_WR: begin
                o_cmd.op = OP_REL_FREE;
                n_state  = i_stat.rel_last ? S_REL_END : S_REL_RD;
            end
            S_REL_END: begin
                o_cmd.op = OP_RELEASED;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/pfa_datapath.sv =====
// Datapath of the page frame allocator: tables, free queue, page map memory and result registers.
`default_nettype none

module pfa_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfa_pkg::t_cmd                 i_cmd,
    output pfa_pkg::t_stat                o_stat,
    input  logic                          i_func,
    input  logic [pfa_pkg::PROC_W-1:0]    i_proc,
    input  logic [pfa_pkg::PAGE_W-1:0]    i_page,
    input  logic [pfa_pkg::START_W-1:0]   i_rand_start,
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic [pfa_pkg::STATUS_W-1:0]  o_status,
    output logic [pfa_pkg::FRAME_W-1:0]   o_frame,
    output logic [pfa_pkg::LINE_ADDR_W-1:0] o_line_address,
    output logic [pfa_pkg::PROC_W-1:0]    o_evicted_proc,
    output logic [pfa_pkg::PAGE_W-1:0]    o_evicted_page,
    output logic [pfa_pkg::FREED_W-1:0]   o_frames_freed
);
    import pfa_pkg::*;

    localparam int SUM_W = FIDX_W + 1;

    // Latched request.
    logic [PROC_W-1:0]  r_proc;
    logic [PAGE_W-1:0]  r_page;
    logic [FIDX_W-1:0]  r_start;

    // Walk counters.
    logic [FIDX_W-1:0]  r_scan;
    logic [PAGE_W-1:0]  r_rel_page;

    // Free frame queue.
    logic [FIDX_W-1:0]  r_queue [FRAMES];
    logic [FIDX_W-1:0]  r_head;
    logic [FIDX_W-1:0]  r_tail;
    logic [COUNT_W-1:0] r_count;

    // Frame owner table; the page is kept per frame so an eviction needs no table walk.
    logic               r_own_valid [FRAMES];
    logic [PROC_W-1:0]  r_own_proc  [FRAMES];
    logic [PAGE_W-1:0]  r_own_page  [FRAMES];

    // Page table: valid bits in flops, frame numbers in a memory.
    logic               r_map_valid [MAP_ENTRIES];
    logic [FIDX_W-1:0]  r_map_frame [MAP_ENTRIES];
    logic [FIDX_W-1:0]  r_rd_data;

    // Pending result.
    t_status            r_res_status;
    logic [FIDX_W-1:0]  r_res_frame;
    logic [PROC_W-1:0]  r_res_eproc;
    logic [PAGE_W-1:0]  r_res_epage;
    logic [FREED_W-1:0] r_res_freed;

    // Output register.
    logic               r_out_valid;
    t_status            r_out_status;
    logic [FIDX_W-1:0]  r_out_frame;
    logic [PROC_W-1:0]  r_out_eproc;
    logic [PAGE_W-1:0]  r_out_epage;
    logic [FREED_W-1:0] r_out_freed;

    logic [MAP_IDX_W-1:0] req_idx;
    logic [MAP_IDX_W-1:0] rel_idx;
    logic [MAP_IDX_W-1:0] rd_addr;
    logic [MAP_IDX_W-1:0] evict_idx;
    logic [SUM_W-1:0]     scan_sum;
    logic [FIDX_W-1:0]    scan_f;
    logic [FIDX_W-1:0]    alloc_f;
    logic [FIDX_W-1:0]    rel_f;
    logic [PROC_W-1:0]    victim_proc;
    logic [PAGE_W-1:0]    victim_page;
    logic                 out_free;
    logic                 mem_we;
    logic [FIDX_W-1:0]    mem_wdata;

    // Addresses and candidate frames.
    always_comb begin
        req_idx     = map_index(r_proc, r_page);
        rel_idx     = map_index(r_proc, r_rel_page);
        rd_addr     = (i_cmd.op == OP_LOAD) ? map_index(i_proc, i_page) : rel_idx;
        scan_sum    = {1'b0, r_start} + {1'b0, r_scan};
        scan_f      = (scan_sum >= SUM_W'(FRAMES)) ? FIDX_W'(scan_sum - SUM_W'(FRAMES))
                                                   : FIDX_W'(scan_sum);
        victim_proc = r_own_proc[scan_f];
        victim_page = r_own_page[scan_f];
        evict_idx   = map_index(victim_proc, victim_page);
        alloc_f     = r_queue[r_head];
        rel_f       = r_rd_data;
        out_free    = !r_out_valid || i_ready;
        mem_we      = (i_cmd.op == OP_ALLOC) || (i_cmd.op == OP_EVICT);
        mem_wdata   = (i_cmd.op == OP_ALLOC) ? alloc_f : scan_f;
    end

    // Status toward the controller.
    always_comb begin
        o_stat.func       = i_func;
        o_stat.proc_bad   = 32'(r_proc) >= PROCS;
        o_stat.page_bad   = 32'(r_page) >= PAGES_PER_PROC;
        o_stat.hit        = r_map_valid[req_idx];
        o_stat.free_avail = r_count != '0;
        o_stat.victim_ok  = r_own_valid[scan_f] && (victim_proc != r_proc);
        o_stat.scan_last  = r_scan == FIDX_W'(FRAMES - 1);
        o_stat.rel_valid  = r_map_valid[rel_idx];
        o_stat.rel_last   = r_rel_page == PAGE_W'(PAGES_PER_PROC - 1);
        o_stat.out_free   = out_free;
    end

    // Page map memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map_frame[req_idx] <= mem_wdata;
        end
        r_rd_data <= r_map_frame[rd_addr];
    end

    // Queue, ownership, valid bits and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FRAMES; i++) begin
                r_queue[i]     <= FIDX_W'(i);
                r_own_valid[i] <= 1'b0;
                r_own_proc[i]  <= '0;
            end
            for (int j = 0; j < MAP_ENTRIES; j++) begin
                r_map_valid[j] <= 1'b0;
            end
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= COUNT_W'(FRAMES);
            r_out_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_ALLOC: begin
                    r_head               <= frame_inc(r_head);
                    r_count              <= r_count - COUNT_W'(1);
                    r_own_valid[alloc_f] <= 1'b1;
                    r_own_proc[alloc_f]  <= r_proc;
                    r_map_valid[req_idx] <= 1'b1;
                end
                OP_EVICT: begin
                    // The victim belongs to another process, so the two entries differ.
                    r_map_valid[evict_idx] <= 1'b0;
                    r_map_valid[req_idx]   <= 1'b1;
                    r_own_proc[scan_f]     <= r_proc;
                end
                OP_REL_FREE: begin
                    r_own_valid[rel_f]   <= 1'b0;
                    r_own_proc[rel_f]    <= '0;
                    r_map_valid[rel_idx] <= 1'b0;
                    if (r_count < COUNT_W'(FRAMES)) begin
                        r_queue[r_tail] <= rel_f;
                        r_tail          <= frame_inc(r_tail);
                        r_count         <= r_count + COUNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request latch, counters, owner pages and result registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_proc      <= i_proc;
                r_page      <= i_page;
                r_start     <= FIDX_W'(32'(i_rand_start) % FRAMES);
                r_scan      <= '0;
                r_rel_page  <= '0;
                r_res_freed <= '0;
            end
            OP_HIT: begin
                r_res_status <= STAT_HIT;
                r_res_frame  <= r_rd_data;
                r_res_eproc  <= '0;
                r_res_epage  <= '0;
            end
            OP_ALLOC: begin
                r_own_page[alloc_f] <= r_page;
                r_res_status        <= STAT_FREE;
                r_res_frame         <= alloc_f;
                r_res_eproc         <= '0;
                r_res_epage         <= '0;
            end
            OP_EVICT: begin
                r_own_page[scan_f] <= r_page;
                r_res_status       <= STAT_EVICT;
                r_res_frame        <= scan_f;
                r_res_eproc        <= victim_proc;
                r_res_epage        <= victim_page;
            end
            OP_NOFRAME: begin
                r_res_status <= STAT_NOFRAME;
                r_res_frame  <= '0;
                r_res_eproc  <= '0;
                r_res_epage  <= '0;
            end
            OP_SCAN_NEXT: begin
                r_scan <= r_scan + FIDX_W'(1);
            end
            OP_REL_NEXT: begin
                r_rel_page <= r_rel_page + PAGE_W'(1);
            end
            OP_REL_FREE: begin
                r_rel_page  <= r_rel_page + PAGE_W'(1);
                r_res_freed <= r_res_freed + FREED_W'(1);
            end
            OP_RELEASED: begin
                r_res_status <= STAT_RELEASED;
                r_res_frame  <= '0;
                r_res_eproc  <= '0;
                r_res_epage  <= '0;
            end
            default: begin
            end
        endcase
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_frame  <= r_res_frame;
            r_out_eproc  <= r_res_eproc;
            r_out_epage  <= r_res_epage;
            r_out_freed  <= r_res_freed;
        end
    end

    // Output ports; the line address is the frame scaled by the lines per frame.
    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_frame        = FRAME_W'(r_out_frame);
    assign o_line_address = LINE_ADDR_W'({r_out_frame, {LINE_OFS_W{1'b0}}});
    assign o_evicted_proc = r_out_eproc;
    assign o_evicted_page = r_out_epage;
    assign o_frames_freed = r_out_freed;

endmodule

`default_nettype wire

// ===== rtl/page_frame_allocator_core.sv =====
// Top level of the page frame allocator: controller, datapath and checks.
//
//  Channel   Direction  Handshake           Payload
//  request   in         i_valid / o_ready   i_func, i_proc, i_page, i_rand_start
//  result    out        o_valid / i_ready   o_status, o_frame, o_line_address,
//                                           o_evicted_proc, o_evicted_page, o_frames_freed
//
// A hit or a free-frame map passes from acceptance through S_LOOK to S_DONE, where the result is loaded.
// An eviction, and a map that finds no victim, first run the victim scan, which checks one
// owner entry per cycle; a map that finds no victim scans every owner entry.
// A release walks the page table one unmapped page per cycle; a mapped page also passes
// through S_REL_WR, which frees the frame read from the page map memory, and when the last
// page is mapped the walk ends through S_REL_END.
// Reset is synchronous and needs no clearing pass; the next request is taken once the
// result has moved into the output register, which holds it while i_ready is low.
`default_nettype none

`include "page_frame_allocator_core_defines.svh"

module page_frame_allocator_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic                            i_func,
    input  logic [pfa_pkg::PROC_W-1:0]      i_proc,
    input  logic [pfa_pkg::PAGE_W-1:0]      i_page,
    input  logic [pfa_pkg::START_W-1:0]     i_rand_start,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pfa_pkg::STATUS_W-1:0]    o_status,
    output logic [pfa_pkg::FRAME_W-1:0]     o_frame,
    output logic [pfa_pkg::LINE_ADDR_W-1:0] o_line_address,
    output logic [pfa_pkg::PROC_W-1:0]      o_evicted_proc,
    output logic [pfa_pkg::PAGE_W-1:0]      o_evicted_page,
    output logic [pfa_pkg::FREED_W-1:0]     o_frames_freed
);
    import pfa_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    pfa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    // Tables, queue and result registers.
    pfa_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_func         (i_func),
        .i_proc         (i_proc),
        .i_page         (i_page),
        .i_rand_start   (i_rand_start),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_frame        (o_frame),
        .o_line_address (o_line_address),
        .o_evicted_proc (o_evicted_proc),
        .o_evicted_page (o_evicted_page),
        .o_frames_freed (o_frames_freed)
    );

    // A result is only loaded when the output register is empty or being drained.
    `PFA_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, cmd.out_load, stat.out_free)
    // No result is loaded while a new request can be taken.
    `PFA_ASSERT_IMPL(a_no_load_in_idle, i_clk, i_rst_n, o_ready, !cmd.out_load)
    // An accepted transaction keeps the request channel closed in the next cycle.
    `PFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

endmodule

`default_nettype wire
